### rtl/core/drbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_pkg
// Shared types, codes and AES helper functions for the counter-mode DRBG block.
// ----------------------------------------------------------------------------
package drbg_pkg;

   localparam int MaxBlocks = 16;
   localparam logic [20:0] ResetLimit = 21'd1048576;
   localparam logic [20:0] CountMax = 21'h1FFFFF;

   typedef enum logic [1:0] {
      OP_INSTANTIATE = 2'd0,
      OP_RESEED      = 2'd1,
      OP_GENERATE    = 2'd2,
      OP_UNUSED      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_RESEED_NEED = 2'd1,
      ST_BAD_ARG     = 2'd2,
      ST_SPARE       = 2'd3
   } status_type;

   // control from sequencer to the AES core
   typedef struct packed {
      logic start;
      logic [127:0] key;
      logic [127:0] block;
   } aes_req_type;

   typedef struct packed {
      logic done;
      logic [127:0] block;
   } aes_rsp_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [256];
      t = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a 128-bit big-endian block
   function automatic logic [7:0] byte_at(input logic [127:0] b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   // next round key from the current one
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {sbox(w3[23:16]) ^ rc, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // SubBytes, ShiftRows and, unless final, MixColumns
   function automatic logic [127:0] round_fn(input logic [127:0] s, input logic final_rnd);
      logic [7:0] t [16];
      logic [7:0] a0, a1, a2, a3, m;
      logic [127:0] o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            t[r + 4*c] = sbox(byte_at(s, r + 4*((c + r) & 3)));
      if (!final_rnd) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
            m = a0 ^ a1 ^ a2 ^ a3;
            t[4*c]   = a0 ^ m ^ xtime(a0 ^ a1);
            t[4*c+1] = a1 ^ m ^ xtime(a1 ^ a2);
            t[4*c+2] = a2 ^ m ^ xtime(a2 ^ a3);
            t[4*c+3] = a3 ^ m ^ xtime(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = t[i];
      return o;
   endfunction

endpackage

### rtl/core/aes128_ctr_drbg_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_drbg_top
// AES-128 counter-mode DRBG without derivation function: sequencer, state and
// stream ports.
// ----------------------------------------------------------------------------
// One request beat at a time, all work done on a single iterative AES round
// unit. Instantiate and reseed run two AES blocks and answer once the second
// one is done. Generate of n blocks runs n+2 AES blocks; each block but the
// last waits until its beat is taken before the next one starts. Rejected
// requests answer in the cycle after acceptance. No new request is taken
// until the last response beat has gone.
module aes128_ctr_drbg_top
   import drbg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // operation[1:0], seed_word0[65:2], seed_word1[129:66], seed_word2[193:130],
   // seed_word3[257:194], byte_count[266:258], zero pad
   input  logic [271:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], random_high[65:2], random_low[129:66], zero pad
   output logic [135:0] rsp_tdata,
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [20:0]  csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_UPD_K, S_UPD_V, S_GEN, S_OUT, S_RSP
   } state_type;

   state_type    state_ff;
   logic [127:0] key_ff, ctr_ff, nkey_ff;
   logic [255:0] seed_ff;
   logic [20:0]  count_ff, limit_ff;
   logic [4:0]   left_ff;
   logic         gen_ff;
   logic         rvalid_ff, rlast_ff;
   logic [1:0]   rstat_ff;
   logic [127:0] rdata_ff;
   aes_req_type  areq;
   aes_rsp_type  arsp;

   op_type       op;
   logic [8:0]   bytes;
   logic [127:0] ctr_inc;
   logic         bad;
   logic         refuse;
   logic         rsp_free;
   logic         rsp_load;

   assign op      = op_type'(req_tdata[1:0]);
   assign bytes   = req_tdata[266:258];
   assign ctr_inc = ctr_ff + 128'd1;
   assign bad     = (op == OP_UNUSED)
                    || (op == OP_GENERATE && ((bytes == 9'd0) || (bytes[3:0] != 4'd0)
                                              || (bytes > 9'(MaxBlocks * 16))));
   assign refuse  = (op == OP_GENERATE) && (count_ff > limit_ff);
   assign rsp_free = !rvalid_ff || rsp_tready;

   drbg_aes_core u_aes (.clock(clock), .reset(reset), .req(areq), .rsp(arsp));

   assign req_tready = (state_ff == S_IDLE) && !rvalid_ff;

   always_comb begin
      areq.start = 1'b0;
      areq.key   = key_ff;
      areq.block = ctr_inc;
      if (state_ff == S_IDLE && req_tvalid && req_tready && !bad && !refuse) begin
         areq.start = 1'b1;
         if (op == OP_INSTANTIATE) begin
            areq.key   = '0;
            areq.block = 128'd1;
         end
      end else if (arsp.done && (state_ff == S_UPD_K
                   || (state_ff == S_GEN && left_ff == 5'd1 && rsp_free))) begin
         areq.start = 1'b1;
      end else if (state_ff == S_RSP && left_ff == 5'd0 && rsp_free) begin
         areq.start = 1'b1;
      end else if (state_ff == S_OUT && !rvalid_ff) begin
         areq.start = 1'b1;
      end
   end

   always_comb begin
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE:  rsp_load = req_tvalid && req_tready && (bad || refuse);
         S_GEN:   rsp_load = arsp.done && left_ff == 5'd1 && rsp_free;
         S_RSP:   rsp_load = rsp_free;
         S_UPD_V: rsp_load = arsp.done && !gen_ff;
         default: rsp_load = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         key_ff    <= '0;
         ctr_ff    <= '0;
         count_ff  <= '0;
         limit_ff  <= ResetLimit;
         rvalid_ff <= 1'b0;
         left_ff   <= '0;
         gen_ff    <= 1'b0;
      end else begin
         if (csr_we) limit_ff <= csr_wdata;
         if (rsp_load) rvalid_ff <= 1'b1;
         else if (rsp_tready) rvalid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid && req_tready) begin
                  seed_ff <= {req_tdata[257:194], req_tdata[193:130],
                              req_tdata[129:66], req_tdata[65:2]};
                  if (bad) begin
                     rstat_ff <= ST_BAD_ARG; rdata_ff <= '0; rlast_ff <= 1'b1;
                  end else if (op == OP_GENERATE) begin
                     if (refuse) begin
                        rstat_ff <= ST_RESEED_NEED; rdata_ff <= '0; rlast_ff <= 1'b1;
                     end else begin
                        ctr_ff  <= ctr_inc;
                        left_ff <= 5'(bytes[8:4]);
                        gen_ff  <= 1'b1;
                        state_ff <= S_GEN;
                     end
                  end else begin
                     if (op == OP_INSTANTIATE) begin
                        key_ff <= '0;
                        ctr_ff <= 128'd1;
                     end else ctr_ff <= ctr_inc;
                     gen_ff   <= 1'b0;
                     state_ff <= S_UPD_K;
                  end
               end
            end
            S_GEN: begin
               if (arsp.done) begin
                  rstat_ff <= ST_OK; rdata_ff <= arsp.block;
                  rlast_ff <= (left_ff == 5'd1);
                  if (left_ff == 5'd1 && rsp_free) begin
                     ctr_ff   <= ctr_inc;
                     seed_ff  <= '0;
                     state_ff <= S_UPD_K;
                  end else state_ff <= S_RSP;
                  left_ff <= left_ff - 5'd1;
               end
            end
            S_RSP: begin
               // hold the block until the output register is free
               if (rsp_free) begin
                  if (left_ff == 5'd0) begin
                     seed_ff  <= '0;
                     state_ff <= S_UPD_K;
                     ctr_ff   <= ctr_inc;
                  end else state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (!rvalid_ff) begin
                  ctr_ff   <= ctr_inc;
                  state_ff <= S_GEN;
               end
            end
            S_UPD_K: begin
               if (arsp.done) begin
                  nkey_ff  <= arsp.block ^ {seed_ff[63:0], seed_ff[127:64]};
                  ctr_ff   <= ctr_inc;
                  state_ff <= S_UPD_V;
               end
            end
            S_UPD_V: begin
               if (arsp.done) begin
                  key_ff <= nkey_ff;
                  ctr_ff <= arsp.block ^ {seed_ff[191:128], seed_ff[255:192]};
                  if (gen_ff) begin
                     if (count_ff != CountMax) count_ff <= count_ff + 21'd1;
                     state_ff <= S_IDLE;
                  end else begin
                     count_ff <= 21'd1;
                     rstat_ff <= ST_OK; rdata_ff <= '0; rlast_ff <= 1'b1;
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rvalid_ff;
   assign rsp_tlast  = rlast_ff;
   assign rsp_tdata  = {6'd0, rdata_ff[63:0], rdata_ff[127:64], rstat_ff};

endmodule

### rtl/core/drbg_aes_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drbg_aes_core
// Iterative AES-128 encryption: one round and one key-schedule step per cycle.
// ----------------------------------------------------------------------------
module drbg_aes_core
   import drbg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  aes_req_type req,
   output aes_rsp_type rsp
);

   logic [127:0] state_ff, state_in;
   logic [127:0] rkey_ff, rkey_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic [3:0]   round_ff, round_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;
   logic [127:0] nk;

   assign nk = next_key(rkey_ff, rcon_ff);

   always_comb begin
      state_in = state_ff;
      rkey_in  = rkey_ff;
      rcon_in  = rcon_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         state_in = req.block ^ req.key;
         rkey_in  = req.key;
         rcon_in  = 8'h01;
         round_in = 4'd1;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         state_in = round_fn(state_ff, round_ff == 4'd10) ^ nk;
         rkey_in  = nk;
         rcon_in  = xtime(rcon_ff);
         round_in = round_ff + 4'd1;
         if (round_ff == 4'd10) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= 4'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      state_ff <= state_in;
      rkey_ff  <= rkey_in;
      rcon_ff  <= rcon_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.block = state_ff;

endmodule

### bench/aes128_ctr_drbg_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_ctr_drbg_top_tb
// Self-checking bench for the AES-128 counter-mode DRBG block. Until the last
// phase, request beats get random gaps and the response stalls at random;
// every response beat is checked against a local AES / DRBG state predictor.
// ----------------------------------------------------------------------------
module aes128_ctr_drbg_top_tb;
   import drbg_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [63:0] hi;
      logic [63:0] lo;
      logic        last;
   } drbg_beat_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [271:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         rsp_tlast;
   logic         csr_we;
   logic [20:0]  csr_wdata;

   aes128_ctr_drbg_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast), .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic [127:0] p_key;
   logic [127:0] p_ctr;
   logic [20:0]  p_count;
   logic [20:0]  p_limit;

   drbg_beat_type exp_beats[$];
   int errors;
   int n_req;
   int n_rsp;
   bit idle_en;
   int stall_hold;

   localparam logic [7:0] SBOX [256] = '{
8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

   function automatic logic [7:0] gf_dbl(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // byte i of a block, byte 0 in the top bits
   function automatic logic [7:0] blk_byte(input logic [127:0] b, input int i);
      return b[127 - 8*i -: 8];
   endfunction

   function automatic logic [127:0] aes_encrypt(input logic [127:0] key,
                                                input logic [127:0] pt);
      logic [7:0] rk [176];
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [7:0] w [4];
      logic [7:0] x, a0, a1, a2, a3, m;
      logic [7:0] rc;
      logic [127:0] o;
      rc = 8'h01;
      for (int i = 0; i < 16; i++) rk[i] = blk_byte(key, i);
      for (int i = 4; i < 44; i++) begin
         for (int j = 0; j < 4; j++) w[j] = rk[4*(i-1)+j];
         if ((i & 3) == 0) begin
            x = w[0];
            w[0] = SBOX[w[1]] ^ rc;
            w[1] = SBOX[w[2]];
            w[2] = SBOX[w[3]];
            w[3] = SBOX[x];
            rc = gf_dbl(rc);
         end
         for (int j = 0; j < 4; j++) rk[4*i+j] = rk[4*(i-4)+j] ^ w[j];
      end
      for (int i = 0; i < 16; i++) s[i] = blk_byte(pt, i) ^ rk[i];
      for (int rnd = 1; rnd <= 10; rnd++) begin
         for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
               t[r + 4*c] = SBOX[s[r + 4*((c + r) & 3)]];
         if (rnd != 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
               m = a0 ^ a1 ^ a2 ^ a3;
               t[4*c]   = a0 ^ m ^ gf_dbl(a0 ^ a1);
               t[4*c+1] = a1 ^ m ^ gf_dbl(a1 ^ a2);
               t[4*c+2] = a2 ^ m ^ gf_dbl(a2 ^ a3);
               t[4*c+3] = a3 ^ m ^ gf_dbl(a3 ^ a0);
            end
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[16*rnd + i];
      end
      for (int i = 0; i < 16; i++) o[127 - 8*i -: 8] = s[i];
      return o;
   endfunction

   function automatic void drbg_update(input logic [255:0] provided);
      logic [127:0] k_new, v_new;
      p_ctr = p_ctr + 1;
      k_new = aes_encrypt(p_key, p_ctr);
      p_ctr = p_ctr + 1;
      v_new = aes_encrypt(p_key, p_ctr);
      p_key = k_new ^ provided[255:128];
      p_ctr = v_new ^ provided[127:0];
   endfunction

   function automatic void push_status(input status_type st);
      drbg_beat_type b;
      b = '{st, 64'd0, 64'd0, 1'b1};
      exp_beats.push_back(b);
   endfunction

   function automatic void predict_drbg(input op_type op, input logic [255:0] seed,
                                        input logic [8:0] nbytes);
      drbg_beat_type b;
      logic [127:0] blk;
      int n;
      if (op == OP_INSTANTIATE || op == OP_RESEED) begin
         if (op == OP_INSTANTIATE) begin
            p_key = '0;
            p_ctr = '0;
         end
         drbg_update(seed);
         p_count = 21'd1;
         push_status(ST_OK);
      end else if (op == OP_UNUSED || nbytes == 0 || nbytes[3:0] != 0 ||
                   nbytes > MaxBlocks * 16) begin
         push_status(ST_BAD_ARG);
      end else if (p_count > p_limit) begin
         push_status(ST_RESEED_NEED);
      end else begin
         n = nbytes >> 4;
         for (int i = 0; i < n; i++) begin
            p_ctr = p_ctr + 1;
            blk = aes_encrypt(p_key, p_ctr);
            b = '{ST_OK, blk[127:64], blk[63:0], (i == n - 1)};
            exp_beats.push_back(b);
         end
         drbg_update('0);
         if (p_count != CountMax) p_count = p_count + 1;
      end
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("DONE: errors detected");
      $finish;
   end

   task automatic send_req(input op_type op, input logic [255:0] seed,
                           input logic [8:0] nbytes);
      if (idle_en && $urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 5)) @(negedge clock);
      req_tdata = {5'd0, nbytes, seed[63:0], seed[127:64], seed[191:128],
                   seed[255:192], op};
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_drbg(op, seed, nbytes);
      n_req++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic wait_drained();
      while (exp_beats.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
   endtask

   task automatic write_limit(input logic [20:0] v);
      wait_drained();
      csr_wdata <= v;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      p_limit = v;
   endtask

   function automatic logic [255:0] rand_seed();
      return {$urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [8:0] rand_bytes();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 9'($urandom);
      if (k == 1) return 9'd256;
      return 9'(16 * $urandom_range(1, 4));
   endfunction

   task automatic test_directed();
      send_req(OP_GENERATE, '0, 9'd16);
      send_req(OP_INSTANTIATE, '0, 9'd0);
      send_req(OP_GENERATE, '0, 9'd32);
      send_req(OP_INSTANTIATE, '1, 9'h1FF);
      send_req(OP_GENERATE, '1, 9'd256);
      send_req(OP_GENERATE, '0, 9'd0);
      send_req(OP_GENERATE, '0, 9'd8);
      send_req(OP_GENERATE, '0, 9'd272);
      send_req(OP_GENERATE, '0, 9'h1F0);
      send_req(OP_UNUSED, rand_seed(), 9'd16);
      send_req(OP_RESEED, rand_seed(), 9'd16);
      send_req(OP_GENERATE, rand_seed(), 9'd48);
      send_req(OP_INSTANTIATE, {128'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFE}, 9'd0);
      send_req(OP_GENERATE, '0, 9'd64);
   endtask

   task automatic test_reseed_limit();
      write_limit(21'd1);
      send_req(OP_RESEED, rand_seed(), 9'd0);
      send_req(OP_GENERATE, '0, 9'd16);
      send_req(OP_GENERATE, '0, 9'd16);
      write_limit(21'd0);
      send_req(OP_GENERATE, '0, 9'd16);
      write_limit(21'h1FFFFF);
      send_req(OP_GENERATE, '0, 9'd16);
      write_limit(21'd3);
      for (int i = 0; i < 5; i++) send_req(OP_GENERATE, '0, 9'd16);
      write_limit(ResetLimit);
   endtask

   task automatic test_backpressure();
      wait_drained();
      stall_hold = 400;
      for (int i = 0; i < 4; i++) send_req(OP_GENERATE, '0, 9'd64);
   endtask

   task automatic test_random(input int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 9);
         if (k == 0) send_req(OP_INSTANTIATE, rand_seed(), 9'($urandom));
         else if (k == 1) send_req(OP_RESEED, rand_seed(), 9'($urandom));
         else if (k == 2) send_req(OP_UNUSED, rand_seed(), rand_bytes());
         else send_req(OP_GENERATE, rand_seed(), rand_bytes());
      end
   endtask

   // response side: random stalls plus one long hold-off
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall_hold) @(negedge clock);
            stall_hold = 0;
         end
         if (idle_en && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5) - 1) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      drbg_beat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status_type'(rsp_tdata[1:0]), rsp_tdata[65:2], rsp_tdata[129:66],
                 rsp_tlast};
         n_rsp++;
         if (exp_beats.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
         end else begin
            want = exp_beats.pop_front();
            if (got.status != want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               errors++;
            end
            if (got.hi != want.hi) begin
               $display("%0t: random_high exp %h got %h", $time, want.hi, got.hi);
               errors++;
            end
            if (got.lo != want.lo) begin
               $display("%0t: random_low exp %h got %h", $time, want.lo, got.lo);
               errors++;
            end
            if (got.last != want.last) begin
               $display("%0t: last exp %0d got %0d", $time, want.last, got.last);
               errors++;
            end
         end
      end
   end

   initial begin
      errors = 0;
      n_req = 0;
      n_rsp = 0;
      stall_hold = 0;
      idle_en = 1'b1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      p_key = '0;
      p_ctr = '0;
      p_count = '0;
      p_limit = ResetLimit;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_reseed_limit();
      test_backpressure();
      test_random(60);
      wait_drained();
      idle_en = 1'b0;
      test_random(20);
      wait_drained();
      if (exp_beats.size() != 0) begin
         $display("%0t: %0d beats never arrived", $time, exp_beats.size());
         errors++;
      end
      $display("Sent %0d requests, checked %0d response beats", n_req, n_rsp);
      $display("Covered all operations, bad lengths, reseed limits and a long stall");
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

### aes128_ctr_drbg_top.f
rtl/core/drbg_pkg.sv
rtl/core/drbg_aes_core.sv
rtl/core/aes128_ctr_drbg_top.sv
bench/aes128_ctr_drbg_top_tb.sv
